// ===== sv/cpce_pkg.sv =====
`default_nettype none
package cpce_pkg;

	// Result format
	localparam int RATIO_BITS = 32;

	// Status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_DEGEN    = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	// Top level control
	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_EVAL,
		ST_CALC,
		ST_OUT
	} top_state_t;

	// Distance pass sequencer
	typedef enum logic [3:0] {
		CS_IDLE,
		CS_LEN_MUL,
		CS_LEN_ACC,
		CS_READ,
		CS_LOAD,
		CS_CRS_MUL,
		CS_CRS_ACC,
		CS_SQ_MUL,
		CS_SQ_ACC,
		CS_CMP,
		CS_ROOT_GO,
		CS_ROOT_WAIT
	} calc_state_t;

	// Square root / divide unit
	typedef enum logic [1:0] {
		SD_IDLE,
		SD_ROOT,
		SD_DIV,
		SD_DONE
	} sd_state_t;

	// Completion of a ratio computation
	typedef struct packed {
		logic                  done;
		logic [RATIO_BITS-1:0] ratio;
	} ratio_rsp_t;

endpackage
`default_nettype wire

// ===== sv/cpce_if.sv =====
`default_nettype none
// Control point channel
interface cpce_pt_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] x_coord;
	logic signed [COORD_BITS-1:0] y_coord;
	logic signed [COORD_BITS-1:0] z_coord;
	logic                         last_point;

	modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
	modport sink (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

// Result channel
interface cpce_res_if;
	logic                                valid;
	logic                                ready;
	logic [cpce_pkg::RATIO_BITS-1:0]     collinearity_ratio;
	logic [1:0]                          status;

	modport source (output valid, collinearity_ratio, status, input ready);
	modport sink (input valid, collinearity_ratio, status, output ready);
endinterface
`default_nettype wire

// ===== sv/curve_polygon_collinearity_estimate.sv =====
`default_nettype none
// Control polygon flatness test.
// in_pt carries one control point per transaction; last_point closes the
// polygon. out_res carries one transaction per polygon: the largest distance
// of an interior point from the end-point line over the line length, Q16.16,
// rounded down and saturating, with a status (ok, end points coincide,
// too many points). cfg_wr_en / cfg_wr_data write three_d_mode.
// Each point is accepted while in_pt.ready is high. After the
// last point in_pt.ready is low while the polygon is evaluated by a single
// shared multiplier and a bit-serial root / divide unit. Overflow and
// coincident end points skip that evaluation.
// The result waits in an output register; collection of the next polygon
// starts at once, and the next result waits for out_res to take the old one.
// Reset clears the point count, the overflow flag and the output, and sets
// three_d_mode to 1; stored points need no clearing.
module curve_polygon_collinearity_estimate #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cpce_pt_if.sink     in_pt,
	cpce_res_if.source  out_res,
	input  wire logic   cfg_wr_en,
	input  wire logic   cfg_wr_data
);

	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int AW   = $clog2(MAX_POINTS);
	localparam int RB   = cpce_pkg::RATIO_BITS;

	cpce_pkg::top_state_t state_q, state_d;

	logic                          mode_q;
	logic [CNTW-1:0]               count_q;
	logic                          ovf_q;
	logic [2:0][COORD_BITS-1:0]    first_q;
	logic [2:0][COORD_BITS-1:0]    last_q;
	logic [RB-1:0]                 pend_ratio_q;
	logic [1:0]                    pend_status_q;
	logic                          out_valid_q;
	logic [RB-1:0]                 out_ratio_q;
	logic [1:0]                    out_status_q;

	logic                          in_acc;
	logic                          has_room;
	logic                          degen;
	logic                          calc_start;
	logic                          out_load;
	logic [3*COORD_BITS-1:0]       rd_data;
	logic                          rd_en;
	logic [AW-1:0]                 rd_addr;
	cpce_pkg::ratio_rsp_t          calc_rsp;

	assign in_acc   = in_pt.valid & in_pt.ready;
	assign has_room = (count_q < CNTW'(MAX_POINTS));
	assign degen    = (first_q[0] == last_q[0]) && (first_q[1] == last_q[1]) &&
		(!mode_q || (first_q[2] == last_q[2]));

	assign out_res.valid              = out_valid_q;
	assign out_res.collinearity_ratio = out_ratio_q;
	assign out_res.status             = out_status_q;

	// Control sequence
	always_comb begin
		state_d     = state_q;
		in_pt.ready = 1'b0;
		calc_start  = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			cpce_pkg::ST_COLLECT: begin
				in_pt.ready = 1'b1;
				if (in_acc && in_pt.last_point) begin
					state_d = cpce_pkg::ST_EVAL;
				end
			end
			cpce_pkg::ST_EVAL: begin
				if (ovf_q || degen) begin
					state_d = cpce_pkg::ST_OUT;
				end else begin
					calc_start = 1'b1;
					state_d    = cpce_pkg::ST_CALC;
				end
			end
			cpce_pkg::ST_CALC: begin
				if (calc_rsp.done) begin
					state_d = cpce_pkg::ST_OUT;
				end
			end
			cpce_pkg::ST_OUT: begin
				if (!out_valid_q || out_res.ready) begin
					out_load = 1'b1;
					state_d  = cpce_pkg::ST_COLLECT;
				end
			end
			default: state_d = cpce_pkg::ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpce_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// Point count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (out_load) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (in_acc) begin
			if (has_room) begin
				count_q <= count_q + CNTW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// End points and pending result
	always_ff @(posedge clk) begin
		if (in_acc && has_room) begin
			last_q <= {in_pt.z_coord, in_pt.y_coord, in_pt.x_coord};
			if (count_q == '0) begin
				first_q <= {in_pt.z_coord, in_pt.y_coord, in_pt.x_coord};
			end
		end
		if (state_q == cpce_pkg::ST_EVAL) begin
			if (ovf_q) begin
				pend_ratio_q  <= '0;
				pend_status_q <= cpce_pkg::STATUS_OVERFLOW;
			end else begin
				pend_ratio_q  <= '1;
				pend_status_q <= cpce_pkg::STATUS_DEGEN;
			end
		end
		if (calc_rsp.done) begin
			pend_ratio_q  <= calc_rsp.ratio;
			pend_status_q <= cpce_pkg::STATUS_OK;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ratio_q  <= pend_ratio_q;
			out_status_q <= pend_status_q;
		end
	end

	cpce_store #(
		.DEPTH (MAX_POINTS),
		.WIDTH (3 * COORD_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && has_room),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({in_pt.z_coord, in_pt.y_coord, in_pt.x_coord}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	cpce_calc #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (calc_start),
		.use_z   (mode_q),
		.n_pts   (count_q),
		.p_first (first_q),
		.p_last  (last_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rsp     (calc_rsp)
	);

endmodule
`default_nettype wire

// ===== sv/cpce_store.sv =====
`default_nettype none
module cpce_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/cpce_sqdiv.sv =====
`default_nettype none
// Bit-serial integer square root of best * 2^32, then bit-serial division
// of the root by the squared line length. One result bit per cycle.
module cpce_sqdiv #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [4*COORD_BITS+3:0]   best,
	input  wire logic [2*COORD_BITS+1:0]   len2,
	output cpce_pkg::ratio_rsp_t           rsp
);

	localparam int DW  = COORD_BITS + 1;
	localparam int PW  = 2 * DW;
	localparam int SW  = 4 * DW;
	localparam int RB  = cpce_pkg::RATIO_BITS;
	localparam int TW  = SW + RB;
	localparam int RW  = TW / 2;
	localparam int CW  = $clog2(RW);

	cpce_pkg::sd_state_t state_q, state_d;

	logic [TW-1:0]   t_q;
	logic [RW+2:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [PW-1:0]   den_q;
	logic [PW-1:0]   drem_q;
	logic [RW-1:0]   quo_q;
	logic [CW-1:0]   cnt_q;

	logic [RW+2:0]   rem_t;
	logic [RW+2:0]   trial;
	logic            root_ge;
	logic [PW:0]     div_t;
	logic            div_ge;
	logic            last_step;

	// One step of each recurrence
	assign rem_t     = {rem_q[RW:0], t_q[TW-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign root_ge   = (rem_t >= trial);
	assign div_t     = {drem_q, root_q[RW-1]};
	assign div_ge    = (div_t >= {1'b0, den_q});
	assign last_step = (cnt_q == CW'(RW - 1));

	// Next state and response
	always_comb begin
		state_d   = state_q;
		rsp.done  = 1'b0;
		rsp.ratio = (|quo_q[RW-1:RB]) ? '1 : quo_q[RB-1:0];
		case (state_q)
			cpce_pkg::SD_IDLE: begin
				if (start) begin
					state_d = cpce_pkg::SD_ROOT;
				end
			end
			cpce_pkg::SD_ROOT: begin
				if (last_step) begin
					state_d = cpce_pkg::SD_DIV;
				end
			end
			cpce_pkg::SD_DIV: begin
				if (last_step) begin
					state_d = cpce_pkg::SD_DONE;
				end
			end
			cpce_pkg::SD_DONE: begin
				rsp.done = 1'b1;
				state_d  = cpce_pkg::SD_IDLE;
			end
			default: state_d = cpce_pkg::SD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpce_pkg::SD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				cpce_pkg::SD_IDLE: begin
					cnt_q <= '0;
				end
				cpce_pkg::SD_ROOT, cpce_pkg::SD_DIV: begin
					cnt_q <= last_step ? '0 : cnt_q + CW'(1);
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cpce_pkg::SD_IDLE: begin
				if (start) begin
					t_q    <= {best, RB'(0)};
					rem_q  <= '0;
					root_q <= '0;
					den_q  <= len2;
				end
			end
			cpce_pkg::SD_ROOT: begin
				t_q    <= t_q << 2;
				rem_q  <= root_ge ? rem_t - trial : rem_t;
				root_q <= {root_q[RW-2:0], root_ge};
				if (last_step) begin
					drem_q <= '0;
				end
			end
			cpce_pkg::SD_DIV: begin
				drem_q <= div_ge ? PW'(div_t - {1'b0, den_q}) : div_t[PW-1:0];
				quo_q  <= {quo_q[RW-2:0], div_ge};
				root_q <= root_q << 1;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/cpce_calc.sv =====
`default_nettype none
// Distance pass: one shared multiplier walks over the interior points,
// builds |V x D|^2 for each and keeps the largest, then hands off to the
// root / divide unit.
module cpce_calc #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic                               use_z,
	input  wire logic [$clog2(MAX_POINTS+1)-1:0]    n_pts,
	input  wire logic [2:0][COORD_BITS-1:0]         p_first,
	input  wire logic [2:0][COORD_BITS-1:0]         p_last,
	output logic                                    rd_en,
	output logic      [$clog2(MAX_POINTS)-1:0]      rd_addr,
	input  wire logic [3*COORD_BITS-1:0]            rd_data,
	output cpce_pkg::ratio_rsp_t                    rsp
);

	localparam int DW   = COORD_BITS + 1;
	localparam int PW   = 2 * DW;
	localparam int SW   = 4 * DW;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int AW   = $clog2(MAX_POINTS);

	function automatic logic signed [DW-1:0] diff_f(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		diff_f = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
	endfunction

	function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] a);
		mag_f = a[DW-1] ? DW'(-a) : DW'(a);
	endfunction

	function automatic logic [1:0] nxt_f(input logic [1:0] k);
		case (k)
			2'd0:    nxt_f = 2'd1;
			2'd1:    nxt_f = 2'd2;
			default: nxt_f = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] prv_f(input logic [1:0] k);
		case (k)
			2'd0:    prv_f = 2'd2;
			2'd1:    prv_f = 2'd0;
			default: prv_f = 2'd1;
		endcase
	endfunction

	cpce_pkg::calc_state_t state_q, state_d;

	logic                  use_z_q;
	logic signed [DW-1:0]  d_q [3];
	logic signed [DW-1:0]  v_q [3];
	logic [1:0]            k_q;
	logic [1:0]            j_q;
	logic [CNTW-1:0]       i_q;
	logic [PW-1:0]         p_q;
	logic                  psg_q;
	logic [PW-1:0]         lacc_q;
	logic signed [PW:0]    cacc_q;
	logic [PW-1:0]         cmag_q;
	logic [SW-1:0]         sacc_q;
	logic [SW-1:0]         best_q;

	logic signed [DW-1:0]  va;
	logic signed [DW-1:0]  db;
	logic [DW-1:0]         ma;
	logic [DW-1:0]         mb;
	logic                  msg;
	logic signed [PW:0]    term;
	logic signed [PW:0]    csum;
	logic [SW-1:0]         sq_part;
	logic                  more_pts;
	logic                  sd_start;
	cpce_pkg::ratio_rsp_t  sd_rsp;

	assign more_pts = ((CNTW+1)'(i_q) + (CNTW+1)'(2)) < (CNTW+1)'(n_pts);
	assign rd_addr  = i_q[AW-1:0];

	// Shared multiplier operand selection
	always_comb begin
		va  = v_q[nxt_f(k_q)];
		db  = d_q[prv_f(k_q)];
		ma  = '0;
		mb  = '0;
		msg = 1'b0;
		if (j_q[0]) begin
			va = v_q[prv_f(k_q)];
			db = d_q[nxt_f(k_q)];
		end
		case (state_q)
			cpce_pkg::CS_LEN_MUL: begin
				ma = mag_f(d_q[k_q]);
				mb = mag_f(d_q[k_q]);
			end
			cpce_pkg::CS_CRS_MUL: begin
				ma  = mag_f(va);
				mb  = mag_f(db);
				msg = va[DW-1] ^ db[DW-1] ^ j_q[0];
			end
			cpce_pkg::CS_SQ_MUL: begin
				case (j_q)
					2'd0: begin
						ma = cmag_q[PW-1:DW];
						mb = cmag_q[PW-1:DW];
					end
					2'd1: begin
						ma = cmag_q[PW-1:DW];
						mb = cmag_q[DW-1:0];
					end
					default: begin
						ma = cmag_q[DW-1:0];
						mb = cmag_q[DW-1:0];
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Signed cross term and square partial products
	assign term = psg_q ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
	assign csum = cacc_q + term;

	always_comb begin
		case (j_q)
			2'd0:    sq_part = {p_q, PW'(0)};
			2'd1:    sq_part = SW'(p_q) << (DW + 1);
			default: sq_part = SW'(p_q);
		endcase
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		sd_start = 1'b0;
		rsp.done  = 1'b0;
		rsp.ratio = sd_rsp.ratio;
		case (state_q)
			cpce_pkg::CS_IDLE: begin
				if (start) begin
					state_d = cpce_pkg::CS_LEN_MUL;
				end
			end
			cpce_pkg::CS_LEN_MUL: state_d = cpce_pkg::CS_LEN_ACC;
			cpce_pkg::CS_LEN_ACC: begin
				if (k_q != 2'd2) begin
					state_d = cpce_pkg::CS_LEN_MUL;
				end else if (n_pts >= CNTW'(3)) begin
					state_d = cpce_pkg::CS_READ;
				end else begin
					state_d = cpce_pkg::CS_ROOT_GO;
				end
			end
			cpce_pkg::CS_READ: begin
				rd_en   = 1'b1;
				state_d = cpce_pkg::CS_LOAD;
			end
			cpce_pkg::CS_LOAD:    state_d = cpce_pkg::CS_CRS_MUL;
			cpce_pkg::CS_CRS_MUL: state_d = cpce_pkg::CS_CRS_ACC;
			cpce_pkg::CS_CRS_ACC: begin
				state_d = j_q[0] ? cpce_pkg::CS_SQ_MUL : cpce_pkg::CS_CRS_MUL;
			end
			cpce_pkg::CS_SQ_MUL:  state_d = cpce_pkg::CS_SQ_ACC;
			cpce_pkg::CS_SQ_ACC: begin
				if (j_q != 2'd2) begin
					state_d = cpce_pkg::CS_SQ_MUL;
				end else if (k_q != 2'd2) begin
					state_d = cpce_pkg::CS_CRS_MUL;
				end else begin
					state_d = cpce_pkg::CS_CMP;
				end
			end
			cpce_pkg::CS_CMP: begin
				state_d = more_pts ? cpce_pkg::CS_READ : cpce_pkg::CS_ROOT_GO;
			end
			cpce_pkg::CS_ROOT_GO: begin
				sd_start = 1'b1;
				state_d  = cpce_pkg::CS_ROOT_WAIT;
			end
			cpce_pkg::CS_ROOT_WAIT: begin
				if (sd_rsp.done) begin
					rsp.done = 1'b1;
					state_d  = cpce_pkg::CS_IDLE;
				end
			end
			default: state_d = cpce_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpce_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			cpce_pkg::CS_IDLE: begin
				if (start) begin
					use_z_q <= use_z;
					d_q[0]  <= diff_f(p_last[0], p_first[0]);
					d_q[1]  <= diff_f(p_last[1], p_first[1]);
					d_q[2]  <= use_z ? diff_f(p_last[2], p_first[2]) : '0;
					k_q     <= 2'd0;
					lacc_q  <= '0;
					best_q  <= '0;
				end
			end
			cpce_pkg::CS_LEN_MUL, cpce_pkg::CS_CRS_MUL, cpce_pkg::CS_SQ_MUL: begin
				p_q   <= ma * mb;
				psg_q <= msg;
			end
			cpce_pkg::CS_LEN_ACC: begin
				lacc_q <= lacc_q + p_q;
				k_q    <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
				i_q    <= CNTW'(1);
			end
			cpce_pkg::CS_LOAD: begin
				v_q[0] <= diff_f(rd_data[COORD_BITS-1:0], p_first[0]);
				v_q[1] <= diff_f(rd_data[2*COORD_BITS-1:COORD_BITS], p_first[1]);
				v_q[2] <= use_z_q ?
					diff_f(rd_data[3*COORD_BITS-1:2*COORD_BITS], p_first[2]) : '0;
				sacc_q <= '0;
				k_q    <= 2'd0;
				j_q    <= 2'd0;
			end
			cpce_pkg::CS_CRS_ACC: begin
				if (j_q[0]) begin
					cmag_q <= csum[PW] ? PW'(-csum) : PW'(csum);
					j_q    <= 2'd0;
				end else begin
					cacc_q <= term;
					j_q    <= 2'd1;
				end
			end
			cpce_pkg::CS_SQ_ACC: begin
				sacc_q <= sacc_q + sq_part;
				if (j_q == 2'd2) begin
					j_q <= 2'd0;
					k_q <= k_q + 2'd1;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
			cpce_pkg::CS_CMP: begin
				if (sacc_q > best_q) begin
					best_q <= sacc_q;
				end
				i_q <= i_q + CNTW'(1);
			end
			default: begin
			end
		endcase
	end

	cpce_sqdiv #(
		.COORD_BITS(COORD_BITS)
	) u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sd_start),
		.best   (best_q),
		.len2   (lacc_q),
		.rsp    (sd_rsp)
	);

endmodule
`default_nettype wire

// ===== bench/cpce_tb_pkg_if.sv =====
`timescale 1ns / 100ps
// Interfaces come from the RTL; nothing extra is needed here.
package cpce_tb_types;
	// One control point as the bench drives it
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               last;
	} point_t;

	// One result as the bench expects it
	typedef struct {
		logic [31:0] ratio;
		logic [1:0]  status;
	} ratio_t;
endpackage

// ===== bench/curve_polygon_collinearity_estimate_tb.sv =====
`timescale 1ns / 100ps
module curve_polygon_collinearity_estimate_tb;

	localparam int DEPTH = 1024;
	localparam int STALL_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	cpce_pt_if #(.COORD_BITS(16)) in_pt ();
	cpce_res_if out_res ();

	curve_polygon_collinearity_estimate #(.MAX_POINTS(DEPTH), .COORD_BITS(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_pt(in_pt),
		.out_res(out_res),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// Predictor state
	logic signed [15:0] pts_x[DEPTH];
	logic signed [15:0] pts_y[DEPTH];
	logic signed [15:0] pts_z[DEPTH];
	int  n_pts = 0;
	bit  over_full = 1'b0;
	bit  use_z = 1'b1;

	cpce_tb_types::ratio_t expected_q[$];
	int  errors = 0;
	int  table_errors = 0;
	int  n_points_sent = 0;
	int  n_results = 0;
	int  n_degen = 0;
	int  n_ovf = 0;
	int  idle_pct = 0;
	int  stall_pct = 0;
	bit  hold_off = 1'b0;
	int  quiet_cycles = 0;

	// Largest r with (r * len2)^2 <= best * 2^32, held to 32 bits
	function automatic logic [31:0] root_ratio(logic [255:0] best, logic [255:0] len2);
		logic [255:0] target;
		logic [255:0] t;
		logic [63:0]  lo;
		logic [63:0]  hi;
		logic [63:0]  mid;
		target = best << 32;
		lo = 0;
		hi = 64'hFFFF_FFFF;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			t = mid * len2;
			t = t * t;
			if (t <= target)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[31:0];
	endfunction

	// Flatness of the stored polygon
	function automatic cpce_tb_types::ratio_t polygon_flatness();
		cpce_tb_types::ratio_t r;
		logic signed [63:0] d[3];
		logic signed [63:0] v[3];
		logic signed [127:0] dot;
		logic [255:0] len2;
		logic [255:0] vlen2;
		logic [255:0] best;
		logic [255:0] c2;
		int last;
		if (over_full) begin
			r.ratio = 0;
			r.status = cpce_pkg::STATUS_OVERFLOW;
			return r;
		end
		last = n_pts - 1;
		d[0] = pts_x[last] - pts_x[0];
		d[1] = pts_y[last] - pts_y[0];
		d[2] = use_z ? pts_z[last] - pts_z[0] : 0;
		len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
		if (len2 == 0) begin
			r.ratio = 32'hFFFF_FFFF;
			r.status = cpce_pkg::STATUS_DEGEN;
			return r;
		end
		best = 0;
		for (int i = 1; i + 1 < n_pts; i++) begin
			v[0] = pts_x[i] - pts_x[0];
			v[1] = pts_y[i] - pts_y[0];
			v[2] = use_z ? pts_z[i] - pts_z[0] : 0;
			vlen2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
			dot = v[0] * d[0] + v[1] * d[1] + v[2] * d[2];
			if (dot < 0)
				dot = -dot;
			c2 = vlen2 * len2 - 256'(dot) * 256'(dot);
			if (c2 > best)
				best = c2;
		end
		r.ratio = root_ratio(best, len2);
		r.status = cpce_pkg::STATUS_OK;
		return r;
	endfunction

	// Track one accepted point
	task automatic take_point(cpce_tb_types::point_t p);
		if (n_pts < DEPTH) begin
			pts_x[n_pts] = p.x;
			pts_y[n_pts] = p.y;
			pts_z[n_pts] = p.z;
			n_pts++;
		end else begin
			over_full = 1'b1;
		end
		if (p.last) begin
			expected_q.push_back(polygon_flatness());
			n_pts = 0;
			over_full = 1'b0;
		end
	endtask

	// Input driver
	cpce_tb_types::point_t stim_q[$];
	cpce_tb_types::ratio_t directed_q[$];
	bit     directed_known[$];

	task automatic send_point(cpce_tb_types::point_t p);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			in_pt.valid <= 1'b0;
			@(negedge clk);
		end
		in_pt.valid <= 1'b1;
		in_pt.x_coord <= p.x;
		in_pt.y_coord <= p.y;
		in_pt.z_coord <= p.z;
		in_pt.last_point <= p.last;
		@(posedge clk);
		while (!in_pt.ready)
			@(posedge clk);
		take_point(p);
		n_points_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_pt.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		// allow the last evaluation to settle
		repeat (200) @(negedge clk);
	endtask

	task automatic write_mode(bit m);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		use_z = m;
	endtask

	function automatic cpce_tb_types::point_t mk(int x, int y, int z, bit l);
		cpce_tb_types::point_t p;
		p.x = 16'(x);
		p.y = 16'(y);
		p.z = 16'(z);
		p.last = l;
		return p;
	endfunction

	function automatic cpce_tb_types::point_t rnd_point(bit l, int span);
		cpce_tb_types::point_t p;
		if (span >= 65536) begin
			p.x = 16'($urandom);
			p.y = 16'($urandom);
			p.z = 16'($urandom);
		end else begin
			p.x = 16'($urandom_range(2 * span) - span);
			p.y = 16'($urandom_range(2 * span) - span);
			p.z = 16'($urandom_range(2 * span) - span);
		end
		p.last = l;
		return p;
	endfunction

	// Random polygon: mostly short, sometimes wide range, rarely degenerate
	task automatic send_random_polygon();
		int len;
		int span;
		cpce_tb_types::point_t first;
		cpce_tb_types::point_t p;
		len = ($urandom_range(19) == 0) ? 1 : $urandom_range(2, 8);
		span = ($urandom_range(1) == 0) ? 65536 : $urandom_range(1, 300);
		for (int i = 0; i < len; i++) begin
			p = rnd_point(i == len - 1, span);
			if (i == 0)
				first = p;
			if (i == len - 1 && len > 1 && $urandom_range(9) == 0) begin
				p.x = first.x;
				p.y = first.y;
				p.z = use_z ? first.z : 16'($urandom);
			end
			send_point(p);
		end
	endtask

	// Directed table
	task automatic build_directed();
		cpce_tb_types::ratio_t r;
		r.ratio = 32'hFFFF_FFFF; r.status = cpce_pkg::STATUS_DEGEN;
		// single point polygon
		stim_q.push_back(mk(5, -5, 7, 1)); directed_q.push_back(r); directed_known.push_back(1);
		// coincident end points, extreme coordinates
		stim_q.push_back(mk(-32768, 32767, -32768, 0));
		stim_q.push_back(mk(32767, -32768, 32767, 0));
		stim_q.push_back(mk(-32768, 32767, -32768, 1)); directed_q.push_back(r);
		directed_known.push_back(1);
		// two distinct points, no interior: ratio zero
		r.ratio = 0; r.status = cpce_pkg::STATUS_OK;
		stim_q.push_back(mk(-32768, -32768, -32768, 0));
		stim_q.push_back(mk(32767, 32767, 32767, 1)); directed_q.push_back(r);
		directed_known.push_back(1);
		// unit line, far interior point: saturates
		r.ratio = 32'hFFFF_FFFF;
		stim_q.push_back(mk(-32768, -32768, -32768, 0));
		stim_q.push_back(mk(32767, 32767, 32767, 0));
		stim_q.push_back(mk(-32767, -32768, -32768, 1)); directed_q.push_back(r);
		directed_known.push_back(1);
		// right angle, exact half
		stim_q.push_back(mk(0, 0, 0, 0));
		stim_q.push_back(mk(1, 1, 0, 0));
		stim_q.push_back(mk(2, 0, 0, 1));
		r.ratio = 32'h0000_8000; directed_q.push_back(r); directed_known.push_back(1);
		// interior on the line
		stim_q.push_back(mk(-100, 0, 0, 0));
		stim_q.push_back(mk(0, 0, 0, 0));
		stim_q.push_back(mk(100, 0, 0, 1));
		r.ratio = 0; directed_q.push_back(r); directed_known.push_back(1);
		// z only differs: degenerate in 2D, not in 3D
		stim_q.push_back(mk(3, 4, -1000, 0));
		stim_q.push_back(mk(9, 9, 0, 0));
		stim_q.push_back(mk(3, 4, 1000, 1)); directed_q.push_back(r); directed_known.push_back(0);
	endtask

	// Result checker and receiver
	always @(posedge clk) begin
		cpce_tb_types::ratio_t e;
		if (out_res.valid && out_res.ready) begin
			n_results <= n_results + 1;
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: ratio %h status %0d",
					out_res.collinearity_ratio, out_res.status);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_res.collinearity_ratio !== e.ratio) begin
					$error("collinearity_ratio expected %h actual %h",
						e.ratio, out_res.collinearity_ratio);
					errors++;
				end
				if (out_res.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, out_res.status);
					errors++;
				end
				if (e.status == cpce_pkg::STATUS_DEGEN)
					n_degen++;
				if (e.status == cpce_pkg::STATUS_OVERFLOW)
					n_ovf++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off)
			out_res.ready <= 1'b0;
		else
			out_res.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
	end

	// Watchdog on accepted transactions
	always @(posedge clk) begin
		if ((in_pt.valid && in_pt.ready) || (out_res.valid && out_res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Long receiver hold-off, timed in its own process
	task automatic hold_receiver(int cycles);
		hold_off = 1'b1;
		repeat (cycles) @(negedge clk);
		hold_off = 1'b0;
	endtask

	initial begin
		cpce_tb_types::ratio_t r;
		int pi;
		int ri;
		in_pt.valid = 1'b0;
		in_pt.x_coord = '0;
		in_pt.y_coord = '0;
		in_pt.z_coord = '0;
		in_pt.last_point = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows, the known results checked against the predictor too
		build_directed();
		pi = 0;
		ri = 0;
		while (pi < stim_q.size()) begin
			send_point(stim_q[pi]);
			if (stim_q[pi].last) begin
				r = expected_q[expected_q.size() - 1];
				if (directed_known[ri] && (r.ratio !== directed_q[ri].ratio
						|| r.status !== directed_q[ri].status)) begin
					$error("table row %0d: ratio expected %h predicted %h",
						ri, directed_q[ri].ratio, r.ratio);
					table_errors++;
				end
				ri++;
			end
			pi++;
		end
		wait_drained();
		write_mode(1'b0);
		// same z-only polygon in 2D mode reads as coincident
		send_point(mk(3, 4, -1000, 0));
		send_point(mk(9, 9, 0, 0));
		send_point(mk(3, 4, 1000, 1));
		wait_drained();

		// Overflow: one more point than the store holds
		write_mode(1'b1);
		for (int i = 0; i <= DEPTH; i++)
			send_point(rnd_point(i == DEPTH, 100));
		wait_drained();

		// Random phases across idling and mode settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 70; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 70; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			write_mode(ph[2] ? 1'b0 : 1'b1);
			if (ph == 2) begin
				fork
					hold_receiver(3000);
				join_none
			end
			for (int k = 0; k < 5; k++)
				send_random_polygon();
			wait_drained();
		end
		write_mode(1'b1);
		wait_drained();

		$display("Sent %0d points; %0d polygons checked, %0d coincident, %0d overflowed.",
			n_points_sent, n_results, n_degen, n_ovf);
		$display("Both register settings, all idling phases and a long output stall covered.");
		if (errors == 0 && table_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/cpce_pkg.sv
sv/cpce_if.sv
sv/cpce_store.sv
sv/cpce_sqdiv.sv
sv/cpce_calc.sv
sv/curve_polygon_collinearity_estimate.sv
bench/cpce_tb_pkg_if.sv
bench/curve_polygon_collinearity_estimate_tb.sv
